// File: sv/ggss_pkg.sv
// Shared types, constants and address helper for the grid settle sweep unit.
`default_nettype none
package ggss_pkg;

    localparam int GRID_W  = 128;
    localparam int GRID_H  = 64;
    localparam int CELLS   = GRID_W * GRID_H;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int XW      = $clog2(GRID_W);
    localparam int YW      = $clog2(GRID_H);
    localparam int AMT_W   = 8;
    localparam int WORD_W  = AMT_W + 1;
    localparam int AMT_MAX = 255;
    localparam int SPLIT   = 2;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_OBST  = 2'd1,
        CMD_SWEEP = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ACC_RD,
        S_ACC_WAIT,
        S_SW_H,
        S_SW_B,
        S_SW_L,
        S_SW_R,
        S_SW_C,
        S_SW_W1,
        S_SW_W2,
        S_SW_W3,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        TGT_BELOW,
        TGT_DL,
        TGT_DR
    } t_tgt;

    typedef struct packed {
        logic [AMT_W-1:0] h;
        logic             h_solid;
        logic [AMT_W-1:0] b;
        logic             b_solid;
        logic             b_off;
        logic [AMT_W-1:0] l;
        logic             l_solid;
        logic [AMT_W-1:0] r;
        logic             r_solid;
        logic             spill_ok;
    } t_cell_in;

    typedef struct packed {
        logic [AMT_W-1:0] here_val;
        logic             t1_we;
        t_tgt             t1_tgt;
        logic [AMT_W-1:0] t1_val;
        logic             t2_we;
        logic [AMT_W-1:0] t2_val;
    } t_plan;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [XW-1:0] x,
                                                    input logic [YW-1:0] y);
        return ADDR_W'(y) * ADDR_W'(GRID_W) + ADDR_W'(x);
    endfunction

endpackage
`default_nettype wire

// File: sv/granular_grid_settle_sweep_unit.sv
// Top level: command decode, sweep sequencer, grid memory and result register.
//
//  channel | direction | tdata fields (low bit up)                  | tuser
//  s       | in        | col[6:0] row[12:7] amount[20:13]           | cmd[1:0]
//          |           | blocked[21] bottom_drain[22], zero to 23   |
//  m       | out       | read_amount[7:0] done_res[8], zero to 15   | -
//
// After reset a clearing pass writes every one of the 8192 grid words,
// during which no request is taken. Write, obstacle and read requests each read the
// addressed word first; a sweep skips the neighbour reads and writes for empty cells,
// all sequenced by the single read port and single write port of the grid memory.
// The next request is taken once the previous one has moved to the output register.
`default_nettype none
module granular_grid_settle_sweep_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output      logic        o_s_tready,
    input  wire logic [23:0] i_s_tdata,  // col, row, amount, blocked, bottom_drain
    input  wire logic [1:0]  i_s_tuser,  // cmd
    output      logic        o_m_tvalid,
    input  wire logic        i_m_tready,
    output      logic [15:0] o_m_tdata   // read_amount, done_res
);
    import ggss_pkg::*;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_clr, n_clr;
    t_cmd              r_cmd, n_cmd;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [AMT_W-1:0]  r_amount, n_amount;
    logic              r_blocked, n_blocked;
    logic [XW-1:0]     r_x, n_x;
    logic [YW-1:0]     r_y, n_y;
    logic [WORD_W-1:0] r_h, n_h;
    logic [WORD_W-1:0] r_b, n_b;
    logic [WORD_W-1:0] r_l, n_l;
    t_plan             r_plan, n_plan;
    logic [AMT_W-1:0]  r_rd, n_rd;
    logic              r_ovalid, n_ovalid;
    logic [AMT_W-1:0]  r_odata, n_odata;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_q;

    logic [6:0]        in_col;
    logic [5:0]        in_row;
    logic              in_on;
    logic [YW-1:0]     y_dn;
    logic [ADDR_W-1:0] a_here, a_below, a_dl, a_dr, a_tgt;
    logic              b_off;
    logic              last_x;
    logic              last_cell;
    t_cell_in          cur_cell;
    t_plan             plan;

    ggss_ram #(
        .WIDTH(WORD_W),
        .DEPTH(CELLS)
    ) u_grid (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_q)
    );

    ggss_cell_alu u_alu (
        .i_cell(cur_cell),
        .o_plan(plan)
    );

    assign in_col = i_s_tdata[6:0];
    assign in_row = i_s_tdata[12:7];
    assign in_on  = (int'(in_col) < GRID_W) && (int'(in_row) < GRID_H);

    assign y_dn      = r_y + YW'(1);
    assign a_here    = cell_addr(r_x, r_y);
    assign a_below   = cell_addr(r_x, y_dn);
    assign a_dl      = cell_addr(r_x - XW'(1), y_dn);
    assign a_dr      = cell_addr(r_x + XW'(1), y_dn);
    assign b_off     = (r_y == YW'(GRID_H - 1));
    assign last_x    = (r_x == XW'(GRID_W - 1));
    assign last_cell = last_x && (r_y == '0);

    always_comb begin
        unique case (r_plan.t1_tgt)
            TGT_DL:  a_tgt = a_dl;
            TGT_DR:  a_tgt = a_dr;
            default: a_tgt = a_below;
        endcase
    end

    // Cells off the grid below the bottom row read as empty and clear.
    always_comb begin
        cur_cell.h        = r_h[AMT_W-1:0];
        cur_cell.h_solid  = r_h[AMT_W];
        cur_cell.b        = b_off ? '0 : r_b[AMT_W-1:0];
        cur_cell.b_solid  = b_off ? 1'b0 : r_b[AMT_W];
        cur_cell.b_off    = b_off;
        cur_cell.l        = r_l[AMT_W-1:0];
        cur_cell.l_solid  = r_l[AMT_W];
        cur_cell.r        = ram_q[AMT_W-1:0];
        cur_cell.r_solid  = ram_q[AMT_W];
        cur_cell.spill_ok = (r_x != '0) && !last_x;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {7'b0, 1'b1, r_odata};

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_cmd     = r_cmd;
        n_addr    = r_addr;
        n_amount  = r_amount;
        n_blocked = r_blocked;
        n_x       = r_x;
        n_y       = r_y;
        n_h       = r_h;
        n_b       = r_b;
        n_l       = r_l;
        n_plan    = r_plan;
        n_rd      = r_rd;
        n_ovalid  = r_ovalid && !i_m_tready;
        n_odata   = r_odata;
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = '0;
        ram_raddr = r_addr;

        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                n_clr     = r_clr + ADDR_W'(1);
                if (r_clr == ADDR_W'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_cmd     = t_cmd'(i_s_tuser);
                    n_addr    = cell_addr(XW'(in_col), YW'(in_row));
                    n_amount  = i_s_tdata[20:13];
                    n_blocked = i_s_tdata[21];
                    n_rd      = '0;
                    if (t_cmd'(i_s_tuser) == CMD_SWEEP) begin
                        n_x     = '0;
                        n_y     = i_s_tdata[22] ? YW'(GRID_H - 1) : YW'(GRID_H - 2);
                        n_state = S_SW_H;
                    end else if (in_on) begin
                        n_state = S_ACC_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_ACC_RD: begin
                n_state = S_ACC_WAIT;
            end
            S_ACC_WAIT: begin
                case (r_cmd)
                    CMD_WRITE: begin
                        ram_we    = 1'b1;
                        ram_wdata = {ram_q[AMT_W], r_amount};
                    end
                    CMD_OBST: begin
                        ram_we    = 1'b1;
                        ram_wdata = {r_blocked, ram_q[AMT_W-1:0]};
                    end
                    CMD_READ: begin
                        n_rd = ram_q[AMT_W-1:0];
                    end
                    default: begin
                        n_rd = '0;
                    end
                endcase
                n_state = S_DONE;
            end
            S_SW_H: begin
                ram_raddr = a_here;
                n_state   = S_SW_B;
            end
            S_SW_B: begin
                ram_raddr = a_below;
                n_h       = ram_q;
                if (ram_q[AMT_W-1:0] == '0) begin
                    // Empty cell: nothing moves, go straight to the next one.
                    if (last_cell) begin
                        n_state = S_DONE;
                    end else begin
                        n_x     = last_x ? '0 : r_x + XW'(1);
                        n_y     = last_x ? r_y - YW'(1) : r_y;
                        n_state = S_SW_H;
                    end
                end else begin
                    n_state = S_SW_L;
                end
            end
            S_SW_L: begin
                ram_raddr = a_dl;
                n_b       = ram_q;
                n_state   = S_SW_R;
            end
            S_SW_R: begin
                ram_raddr = a_dr;
                n_l       = ram_q;
                n_state   = S_SW_C;
            end
            S_SW_C: begin
                n_plan  = plan;
                n_state = S_SW_W1;
            end
            S_SW_W1: begin
                ram_we    = r_plan.t1_we;
                ram_waddr = a_tgt;
                ram_wdata = {1'b0, r_plan.t1_val};
                n_state   = S_SW_W2;
            end
            S_SW_W2: begin
                ram_we    = r_plan.t2_we;
                ram_waddr = a_dr;
                ram_wdata = {1'b0, r_plan.t2_val};
                n_state   = S_SW_W3;
            end
            S_SW_W3: begin
                ram_we    = 1'b1;
                ram_waddr = a_here;
                ram_wdata = {r_h[AMT_W], r_plan.here_val};
                if (last_cell) begin
                    n_state = S_DONE;
                end else begin
                    n_x     = last_x ? '0 : r_x + XW'(1);
                    n_y     = last_x ? r_y - YW'(1) : r_y;
                    n_state = S_SW_H;
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = r_rd;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_addr    <= n_addr;
        r_amount  <= n_amount;
        r_blocked <= n_blocked;
        r_x       <= n_x;
        r_y       <= n_y;
        r_h       <= n_h;
        r_b       <= n_b;
        r_l       <= n_l;
        r_plan    <= n_plan;
        r_rd      <= n_rd;
        r_odata   <= n_odata;
    end
endmodule
`default_nettype wire

// File: sv/ggss_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ggss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: sv/ggss_cell_alu.sv
// Shared settle unit: decides crush, fall or spill for one cell and its new values.
`default_nettype none
module ggss_cell_alu (
    input  wire ggss_pkg::t_cell_in i_cell,
    output      ggss_pkg::t_plan    o_plan
);
    import ggss_pkg::*;

    logic [AMT_W-1:0] here_eff;
    logic             fall;
    logic             lo;
    logic             ro;
    logic [AMT_W:0]   pour_tot;
    logic [AMT_W-1:0] pour_to;
    logic [AMT_W-1:0] pour_src;
    logic [AMT_W+1:0] tot3;
    logic [AMT_W:0]   half_raw;
    logic [AMT_W-1:0] half;
    logic [AMT_W+1:0] rem3;

    always_comb begin
        here_eff = i_cell.h_solid ? '0 : i_cell.h;
        fall = (i_cell.b < here_eff) && !i_cell.b_solid;
        lo   = i_cell.spill_ok && (i_cell.l < here_eff) && !i_cell.l_solid;
        ro   = i_cell.spill_ok && (i_cell.r < here_eff) && !i_cell.r_solid;

        // The pour partner is below, else whichever diagonal is open.
        if (fall) begin
            pour_src = i_cell.b;
        end else if (lo) begin
            pour_src = i_cell.l;
        end else begin
            pour_src = i_cell.r;
        end
        pour_tot = {1'b0, here_eff} + {1'b0, pour_src};
        pour_to  = (pour_tot > (AMT_W+1)'(AMT_MAX)) ? AMT_W'(AMT_MAX) : pour_tot[AMT_W-1:0];

        tot3 = {2'b00, here_eff} + {2'b00, i_cell.l} + {2'b00, i_cell.r};
        half_raw = tot3[AMT_W+1:1];
        half = (half_raw > (AMT_W+1)'(AMT_MAX)) ? AMT_W'(AMT_MAX) : half_raw[AMT_W-1:0];
        rem3 = tot3 - (AMT_W+2)'(SPLIT) * {2'b00, half};

        o_plan.here_val = here_eff;
        o_plan.t1_we    = 1'b0;
        o_plan.t1_tgt   = TGT_BELOW;
        o_plan.t1_val   = pour_to;
        o_plan.t2_we    = 1'b0;
        o_plan.t2_val   = half;

        if (fall) begin
            o_plan.t1_we    = !i_cell.b_off;
            o_plan.here_val = AMT_W'(pour_tot - {1'b0, pour_to});
        end else if (lo && ro) begin
            o_plan.t1_we    = 1'b1;
            o_plan.t1_tgt   = TGT_DL;
            o_plan.t1_val   = half;
            o_plan.t2_we    = 1'b1;
            o_plan.here_val = rem3[AMT_W-1:0];
        end else if (lo || ro) begin
            o_plan.t1_we    = 1'b1;
            o_plan.t1_tgt   = lo ? TGT_DL : TGT_DR;
            o_plan.here_val = AMT_W'(pour_tot - {1'b0, pour_to});
        end
    end
endmodule
`default_nettype wire

// File: tb/granular_grid_settle_sweep_unit_tb.sv
// Self-checking testbench for the grid settle sweep unit: directed table, then random requests.
`timescale 1ns / 100ps
`default_nettype none
module granular_grid_settle_sweep_unit_tb;
    import ggss_pkg::*;

    localparam longint CYCLE_LIMIT = 8000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata = '0;
    logic [1:0]  i_s_tuser = CMD_WRITE;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;

    granular_grid_settle_sweep_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the grid and obstacle map.
    logic [AMT_W-1:0] snow_shadow [CELLS];
    logic             rock_shadow [CELLS];
    logic [AMT_W-1:0] read_q [$];

    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    longint cycles = 0;

    function automatic int amt_at(int x, int y);
        if (x < 0 || x >= GRID_W || y < 0 || y >= GRID_H) return 0;
        return snow_shadow[y * GRID_W + x];
    endfunction

    function automatic void amt_put(int x, int y, int v);
        if (x >= 0 && x < GRID_W && y >= 0 && y < GRID_H)
            snow_shadow[y * GRID_W + x] = v[7:0];
    endfunction

    function automatic bit is_rock(int x, int y);
        if (x < 0 || x >= GRID_W || y < 0 || y >= GRID_H) return 1'b0;
        return rock_shadow[y * GRID_W + x];
    endfunction

    function automatic void flow_into(int fx, int fy, int tx, int ty);
        int total;
        int moved;
        total = amt_at(fx, fy) + amt_at(tx, ty);
        moved = (total > AMT_MAX) ? AMT_MAX : total;
        amt_put(tx, ty, moved);
        amt_put(fx, fy, total - moved);
    endfunction

    function automatic void settle_grid(bit drain);
        int top_row;
        int here;
        int dl;
        int dr;
        int total;
        int half;
        bit lo;
        bit ro;
        top_row = GRID_H - (drain ? 1 : 2);
        for (int y = top_row; y >= 0; y--) begin
            for (int x = 0; x < GRID_W; x++) begin
                here = amt_at(x, y);
                if (here == 0) continue;
                if (is_rock(x, y)) begin
                    amt_put(x, y, 0);
                    here = 0;
                end
                if (amt_at(x, y + 1) < here && !is_rock(x, y + 1)) begin
                    flow_into(x, y, x, y + 1);
                    continue;
                end
                if (x > 0 && x < GRID_W - 1) begin
                    dl = amt_at(x - 1, y + 1);
                    dr = amt_at(x + 1, y + 1);
                    lo = dl < here && !is_rock(x - 1, y + 1);
                    ro = dr < here && !is_rock(x + 1, y + 1);
                    if (lo && ro) begin
                        total = dl + dr + here;
                        half = total / SPLIT;
                        if (half > AMT_MAX) half = AMT_MAX;
                        amt_put(x - 1, y + 1, half);
                        amt_put(x + 1, y + 1, half);
                        amt_put(x, y, total - SPLIT * half);
                    end else if (lo) begin
                        flow_into(x, y, x - 1, y + 1);
                    end else if (ro) begin
                        flow_into(x, y, x + 1, y + 1);
                    end
                end
            end
        end
    endfunction

    // Applies one command to the shadow state and returns the amount it reads back.
    function automatic logic [7:0] apply_cmd(t_cmd cmd, int col, int row, int amt,
                                             bit blk, bit drain);
        logic [7:0] rd;
        rd = '0;
        case (cmd)
            CMD_WRITE: amt_put(col, row, amt);
            CMD_OBST:  rock_shadow[row * GRID_W + col] = blk;
            CMD_SWEEP: settle_grid(drain);
            default:   rd = 8'(amt_at(col, row));
        endcase
        return rd;
    endfunction

    // Offers one request and waits until it is taken; valid is left high unless a random idle gap drops it.
    task automatic send_req(t_cmd cmd, int col, int row, int amt, bit blk, bit drain,
                            bit typed, int typed_amt);
        logic [7:0] rd;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {1'b0, drain, blk, amt[7:0], row[5:0], col[6:0]};
        do @(posedge i_clk); while (!o_s_tready);
        rd = apply_cmd(cmd, col, row, amt, blk, drain);
        read_q.push_back(typed ? typed_amt[7:0] : rd);
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (read_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_random();
        int pick;
        t_cmd cmd;
        int col;
        int row;
        int amt;
        pick = $urandom_range(99);
        cmd = (pick < 40) ? CMD_WRITE : (pick < 55) ? CMD_OBST :
              (pick < 92) ? CMD_READ : CMD_SWEEP;
        // Most traffic lands in a small patch so sweeps have piles to move.
        if ($urandom_range(3) != 0) begin
            col = $urandom_range(12, 0) + 56;
            row = $urandom_range(8, 0) + 50;
        end else begin
            col = $urandom_range(GRID_W - 1);
            row = $urandom_range(GRID_H - 1);
        end
        amt = ($urandom_range(4) == 0) ? ($urandom_range(1) ? AMT_MAX : 0)
                                       : $urandom_range(AMT_MAX);
        send_req(cmd, col, row, amt, $urandom_range(3) == 0, 1'($urandom_range(1)),
                 1'b0, 0);
    endtask

    typedef struct {
        t_cmd cmd;
        int   col;
        int   row;
        int   amt;
        bit   blk;
        bit   drain;
        bit   typed;
        int   typed_amt;
    } t_dir_row;

    t_dir_row dir_tbl [24] = '{
        '{CMD_READ,    0,  0,   0, 0, 0, 1,   0},  // cleared after reset
        '{CMD_READ,  127, 63,   0, 0, 0, 1,   0},
        '{CMD_WRITE, 127, 63, 255, 0, 0, 0,   0},
        '{CMD_READ,  127, 63,   0, 0, 0, 1, 255},
        '{CMD_WRITE,  10, 20, 100, 0, 0, 0,   0},
        '{CMD_OBST,   10, 20,   0, 1, 0, 0,   0},
        '{CMD_WRITE,   3, 63,  77, 0, 0, 0,   0},
        '{CMD_WRITE,  50, 30, 200, 0, 0, 0,   0},
        '{CMD_WRITE,  50, 31, 100, 0, 0, 0,   0},
        '{CMD_WRITE,  60, 40,  90, 0, 0, 0,   0},
        '{CMD_OBST,   60, 41,   0, 1, 0, 0,   0},
        '{CMD_WRITE,   0, 10,  40, 0, 0, 0,   0},
        '{CMD_OBST,    0, 11,   0, 1, 0, 0,   0},
        '{CMD_SWEEP,   0,  0,   0, 0, 0, 0,   0},
        '{CMD_READ,   10, 20,   0, 0, 0, 1,   0},  // crushed by its obstacle
        '{CMD_READ,    3, 63,   0, 0, 0, 1,  77},  // bottom row kept
        '{CMD_READ,   50, 31,   0, 0, 0, 0,   0},
        '{CMD_READ,   59, 41,   0, 0, 0, 0,   0},
        '{CMD_READ,    0, 10,   0, 0, 0, 0,   0},
        '{CMD_SWEEP, 127,  0, 255, 1, 1, 0,   0},
        '{CMD_READ,    3, 63,   0, 0, 0, 1,   0},  // bottom row drained
        '{CMD_OBST,   10, 20,   0, 0, 0, 0,   0},
        '{CMD_OBST,   60, 41,   0, 0, 0, 0,   0},
        '{CMD_READ,   61, 41,   0, 0, 0, 0,   0}
    };

    // Receiver side: random stalls, one long hold-off on request, and the result check.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (read_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result tdata=%h", o_m_tdata);
            end else begin
                if (o_m_tdata[7:0] !== read_q[0] || o_m_tdata[8] !== 1'b1) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: read_amount exp %0d got %0d, done_res exp 1 got %b",
                                 read_q[0], o_m_tdata[7:0], o_m_tdata[8]);
                end
                void'(read_q.pop_front());
            end
        end
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= $urandom_range(99) >= recv_stall_pct;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < CELLS; i++) begin
            snow_shadow[i] = '0;
            rock_shadow[i] = 1'b0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tbl[i])
            send_req(dir_tbl[i].cmd, dir_tbl[i].col, dir_tbl[i].row, dir_tbl[i].amt,
                     dir_tbl[i].blk, dir_tbl[i].drain, dir_tbl[i].typed,
                     dir_tbl[i].typed_amt);
        drain_results();

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = (phase == 1) ? 64 : (phase == 3) ? 36 : 0;
            recv_stall_pct = (phase == 2) ? 64 : (phase == 3) ? 36 : 0;
            // Hold the sink off at the start of the first phase, so the block fills while the sink is blocked.
            if (phase == 0) hold_cycles = 60000;
            for (int n = 0; n < 18; n++) send_random();
            drain_results();
        end
        // Last look at the patch so late changes are read back.
        send_req(CMD_SWEEP, 0, 0, 0, 0, 1, 1'b0, 0);
        for (int n = 0; n < 8; n++)
            send_req(CMD_READ, 56 + $urandom_range(12), 50 + $urandom_range(13), 0, 0, 0,
                     1'b0, 0);
        drain_results();
        repeat (100) @(posedge i_clk);

        if (errors == 0 && read_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: filelist.f
sv/ggss_pkg.sv
sv/ggss_ram.sv
sv/ggss_cell_alu.sv
sv/granular_grid_settle_sweep_unit.sv
tb/granular_grid_settle_sweep_unit_tb.sv
